// ===== design/dau_pkg.sv =====
// ----------------------------------------------------------------------------
// dau_pkg
// Types, constants and small tables shared by the decimal arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dau_pkg;

	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_MUL    = 2'd1;
	localparam logic [1:0] CMD_DIV    = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_UNINIT  = 2'd2;
	localparam logic [1:0] ST_DIVZERO = 2'd3;

	localparam logic [63:0] COEF_MAX   = 64'd9223372036854775807;
	localparam logic [63:0] COEF_TENTH = 64'd922337203685477580;
	localparam int          PREC       = 19;

	localparam logic signed [17:0] EXP_NONE = -18'sd32768;
	localparam logic signed [17:0] EXP_MIN  = -18'sd32747;
	localparam logic signed [17:0] EXP_MAX  = 18'sd32729;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [63:0] a_coef;
		logic signed [15:0] a_exp;
		logic signed [63:0] b_coef;
		logic signed [15:0] b_exp;
	} in_word_t;

	typedef struct packed {
		logic signed [63:0] res_coef;
		logic signed [15:0] res_exp;
		logic [1:0]         status;
	} out_word_t;

	function automatic logic [63:0] pw10(input logic [4:0] k);
		logic [63:0] v;
		unique case (k)
			5'd0:  v = 64'd1;
			5'd1:  v = 64'd10;
			5'd2:  v = 64'd100;
			5'd3:  v = 64'd1000;
			5'd4:  v = 64'd10000;
			5'd5:  v = 64'd100000;
			5'd6:  v = 64'd1000000;
			5'd7:  v = 64'd10000000;
			5'd8:  v = 64'd100000000;
			5'd9:  v = 64'd1000000000;
			5'd10: v = 64'd10000000000;
			5'd11: v = 64'd100000000000;
			5'd12: v = 64'd1000000000000;
			5'd13: v = 64'd10000000000000;
			5'd14: v = 64'd100000000000000;
			5'd15: v = 64'd1000000000000000;
			5'd16: v = 64'd10000000000000000;
			5'd17: v = 64'd100000000000000000;
			5'd18: v = 64'd1000000000000000000;
			5'd19: v = 64'd10000000000000000000;
			default: v = 64'd0;
		endcase
		return v;
	endfunction

	// half of 10^k, the round-up threshold on the remainder
	function automatic logic [63:0] half10(input logic [4:0] k);
		logic [63:0] v;
		unique case (k)
			5'd1:  v = 64'd5;
			5'd2:  v = 64'd50;
			5'd3:  v = 64'd500;
			5'd4:  v = 64'd5000;
			5'd5:  v = 64'd50000;
			5'd6:  v = 64'd500000;
			5'd7:  v = 64'd5000000;
			5'd8:  v = 64'd50000000;
			5'd9:  v = 64'd500000000;
			5'd10: v = 64'd5000000000;
			5'd11: v = 64'd50000000000;
			5'd12: v = 64'd500000000000;
			5'd13: v = 64'd5000000000000;
			5'd14: v = 64'd50000000000000;
			5'd15: v = 64'd500000000000000;
			5'd16: v = 64'd5000000000000000;
			5'd17: v = 64'd50000000000000000;
			5'd18: v = 64'd500000000000000000;
			5'd19: v = 64'd5000000000000000000;
			default: v = 64'd0;
		endcase
		return v;
	endfunction

	function automatic logic [63:0] mul10_64(input logic [63:0] x);
		return (x << 3) + (x << 1);
	endfunction

	function automatic logic [127:0] mul10_128(input logic [127:0] x);
		return (x << 3) + (x << 1);
	endfunction

endpackage

`default_nettype wire

// ===== design/decimal64_arith_unit.sv =====
// ----------------------------------------------------------------------------
// decimal64_arith_unit
// Decimal add, multiply and divide on signed 64-bit coefficients.
// ----------------------------------------------------------------------------
// Throughput: one word in flight; the next is taken once the result is
// in the output register.
// Reset clears the sequencer, the divider and multiplier start strobes and the output valid; no other state.
`default_nettype none

module decimal64_arith_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              op_valid,
	output logic                   op_stall,
	input  wire dau_pkg::in_word_t op,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output dau_pkg::out_word_t     res
);
	import dau_pkg::*;

	typedef enum logic [4:0] {
		IDLE, CHECK, ADD_HR, ADD_RL, SUM, SUM_R, MUL_RUN, MUL_K, MUL_DIG, MUL_R,
		DIV_DA, DIV_DB, DIV_SC, DIV_Q, DIV_BIG, DIV_T, FIN, FIN_R, FIN_HI,
		DWAIT, EMIT
	} state_t;

	state_t state_q, ret_q;

	logic [1:0]         cmd_q;
	logic               an_q, bn_q;
	logic [63:0]        am_q, bm_q;
	logic signed [17:0] ae_q, be_q;
	logic               neg_q, lneg_q;
	logic [63:0]        mag_q, lm_q;
	logic signed [17:0] e_q;
	logic [127:0]       x_q;
	logic [5:0]         cnt_q;
	logic [4:0]         dd_q, da_q, rk_q;
	logic [1:0]         st_q;
	logic               div_go_q, mul_go_q;
	logic [127:0]       div_n_q;
	logic [63:0]        div_d_q;
	logic               res_valid_q;
	out_word_t          res_q;

	logic               div_done, mul_done;
	logic [127:0]       div_quo, mul_prod;
	logic [63:0]        div_rem;

	dau_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go_q), .num(div_n_q), .den(div_d_q),
		.done(div_done), .quo(div_quo), .rem(div_rem)
	);

	dau_mul u_mul (
		.clk(clk), .arst_n(arst_n), .go(mul_go_q), .a(am_q), .b(bm_q),
		.done(mul_done), .prod(mul_prod)
	);

	logic [63:0]        a_mag, b_mag;
	logic signed [17:0] ediff, esum, eq_ab, m_lo;
	logic [127:0]       qr;
	logic [64:0]        smag;
	logic               sneg;
	logic [5:0]         mt;

	assign a_mag = op.a_coef[63] ? 64'd0 - op.a_coef : op.a_coef;
	assign b_mag = op.b_coef[63] ? 64'd0 - op.b_coef : op.b_coef;
	assign ediff = ae_q - be_q;
	assign esum  = ae_q + be_q;
	assign eq_ab = ediff;
	assign m_lo  = EXP_MIN - e_q;
	assign qr    = div_quo + {127'd0, (div_rem >= half10(rk_q))};
	assign mt    = cnt_q + 6'd19 - {1'b0, da_q};

	always_comb begin
		if (neg_q == lneg_q) begin
			sneg = neg_q;
			smag = {1'b0, mag_q} + {1'b0, lm_q};
		end else if (mag_q >= lm_q) begin
			sneg = neg_q;
			smag = {1'b0, mag_q - lm_q};
		end else begin
			sneg = lneg_q;
			smag = {1'b0, lm_q - mag_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			ret_q       <= IDLE;
			div_go_q    <= 1'b0;
			mul_go_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			mul_go_q <= 1'b0;
			if (res_valid_q && !res_stall && state_q != EMIT)
				res_valid_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (op_valid) begin
						cmd_q   <= op.cmd;
						an_q    <= op.a_coef[63];
						bn_q    <= op.b_coef[63];
						am_q    <= a_mag;
						bm_q    <= b_mag;
						ae_q    <= 18'(op.a_exp);
						be_q    <= 18'(op.b_exp);
						state_q <= CHECK;
					end
				end
				CHECK: begin
					st_q    <= ST_OK;
					neg_q   <= 1'b0;
					mag_q   <= '0;
					e_q     <= '0;
					state_q <= EMIT;
					if (cmd_q == CMD_UNUSED) begin
						st_q <= ST_RANGE;
					end else if (ae_q == EXP_NONE || be_q == EXP_NONE) begin
						st_q <= ST_UNINIT;
					end else if (am_q > COEF_MAX || bm_q > COEF_MAX || ae_q < EXP_MIN ||
							ae_q > EXP_MAX || be_q < EXP_MIN || be_q > EXP_MAX) begin
						st_q <= ST_RANGE;
					end else if (cmd_q == CMD_ADD) begin
						if (am_q == 64'd0) begin
							neg_q <= bn_q; mag_q <= bm_q; e_q <= be_q;
						end else if (bm_q == 64'd0 || eq_ab >= 18'sd19) begin
							neg_q <= an_q; mag_q <= am_q; e_q <= ae_q;
						end else if (eq_ab <= -18'sd19) begin
							neg_q <= bn_q; mag_q <= bm_q; e_q <= be_q;
						end else if (eq_ab == 18'sd0) begin
							neg_q <= an_q; mag_q <= am_q; lneg_q <= bn_q; lm_q <= bm_q;
							e_q <= ae_q; state_q <= SUM;
						end else if (eq_ab > 18'sd0) begin
							neg_q <= an_q; mag_q <= am_q; lneg_q <= bn_q; lm_q <= bm_q;
							e_q <= ae_q; dd_q <= ediff[4:0]; cnt_q <= '0;
							state_q <= ADD_HR;
						end else begin
							neg_q <= bn_q; mag_q <= bm_q; lneg_q <= an_q; lm_q <= am_q;
							e_q <= be_q; dd_q <= 5'(-ediff); cnt_q <= '0;
							state_q <= ADD_HR;
						end
					end else if (cmd_q == CMD_MUL) begin
						if (am_q == 64'd0 || bm_q == 64'd0 || esum + 18'sd39 < EXP_MIN) begin
							st_q <= ST_OK;
						end else if (esum > EXP_MAX) begin
							st_q <= ST_RANGE;
						end else begin
							neg_q    <= an_q ^ bn_q;
							e_q      <= esum;
							mul_go_q <= 1'b1;
							state_q  <= MUL_RUN;
						end
					end else begin
						if (bm_q == 64'd0) begin
							st_q <= ST_DIVZERO;
						end else if (am_q == 64'd0 || ediff + 18'sd19 < EXP_MIN) begin
							st_q <= ST_OK;
						end else if (ediff - 18'sd19 > EXP_MAX + 18'sd18) begin
							st_q <= ST_RANGE;
						end else begin
							neg_q   <= an_q ^ bn_q;
							e_q     <= ediff;
							cnt_q   <= 6'd1;
							state_q <= DIV_DA;
						end
					end
				end
				ADD_HR: begin
					if ({1'b0, cnt_q[4:0]} < {1'b0, dd_q} && mag_q <= COEF_TENTH) begin
						mag_q <= mul10_64(mag_q);
						cnt_q <= cnt_q + 6'd1;
						e_q   <= e_q - 18'sd1;
					end else if (cnt_q[4:0] < dd_q) begin
						div_n_q  <= {64'd0, lm_q};
						div_d_q  <= pw10(dd_q - cnt_q[4:0]);
						rk_q     <= dd_q - cnt_q[4:0];
						div_go_q <= 1'b1;
						ret_q    <= ADD_RL;
						state_q  <= DWAIT;
					end else begin
						state_q <= SUM;
					end
				end
				ADD_RL: begin
					lm_q    <= qr[63:0];
					state_q <= SUM;
				end
				SUM: begin
					neg_q <= sneg;
					mag_q <= smag[63:0];
					st_q  <= ST_OK;
					if (smag > {1'b0, COEF_MAX}) begin
						if (e_q == EXP_MAX) begin
							st_q    <= ST_RANGE;
							state_q <= EMIT;
						end else begin
							e_q      <= e_q + 18'sd1;
							div_n_q  <= {64'd0, smag[63:0]};
							div_d_q  <= pw10(5'd1);
							rk_q     <= 5'd1;
							div_go_q <= 1'b1;
							ret_q    <= SUM_R;
							state_q  <= DWAIT;
						end
					end else begin
						state_q <= EMIT;
					end
				end
				SUM_R: begin
					mag_q   <= qr[63:0];
					state_q <= EMIT;
				end
				MUL_RUN: begin
					if (mul_done) begin
						x_q <= mul_prod;
						if (mul_prod[127:63] != 65'd0) begin
							div_n_q  <= mul_prod;
							div_d_q  <= COEF_MAX;
							div_go_q <= 1'b1;
							ret_q    <= MUL_K;
							state_q  <= DWAIT;
						end else begin
							mag_q   <= mul_prod[63:0];
							state_q <= FIN;
						end
					end
				end
				MUL_K: begin
					lm_q    <= div_quo[63:0] + {63'd0, (div_rem != 64'd0)};
					cnt_q   <= 6'd1;
					state_q <= MUL_DIG;
				end
				MUL_DIG: begin
					if (cnt_q <= 6'd19 && lm_q >= pw10(cnt_q[4:0])) begin
						cnt_q <= cnt_q + 6'd1;
					end else begin
						div_n_q  <= x_q;
						div_d_q  <= pw10(cnt_q[4:0]);
						rk_q     <= cnt_q[4:0];
						e_q      <= e_q + $signed({12'd0, cnt_q});
						div_go_q <= 1'b1;
						ret_q    <= MUL_R;
						state_q  <= DWAIT;
					end
				end
				MUL_R: begin
					mag_q   <= qr[63:0];
					state_q <= FIN;
				end
				DIV_DA: begin
					if (cnt_q <= 6'd19 && am_q >= pw10(cnt_q[4:0])) begin
						cnt_q <= cnt_q + 6'd1;
					end else begin
						da_q    <= cnt_q[4:0];
						cnt_q   <= 6'd1;
						state_q <= DIV_DB;
					end
				end
				DIV_DB: begin
					if (cnt_q <= 6'd19 && bm_q >= pw10(cnt_q[4:0])) begin
						cnt_q <= cnt_q + 6'd1;
					end else begin
						e_q     <= e_q - $signed({12'd0, mt});
						cnt_q   <= mt;
						x_q     <= {64'd0, am_q};
						state_q <= DIV_SC;
					end
				end
				DIV_SC: begin
					if (cnt_q != 6'd0) begin
						x_q   <= mul10_128(x_q);
						cnt_q <= cnt_q - 6'd1;
					end else begin
						div_n_q  <= x_q;
						div_d_q  <= bm_q;
						div_go_q <= 1'b1;
						ret_q    <= DIV_Q;
						state_q  <= DWAIT;
					end
				end
				DIV_Q: begin
					if (div_quo[127:63] == 65'd0 && div_rem != 64'd0 &&
							{div_rem, 1'b0} >= {1'b0, bm_q})
						x_q <= div_quo + 128'd1;
					else
						x_q <= div_quo;
					state_q <= DIV_BIG;
				end
				DIV_BIG: begin
					if (x_q[127:63] != 65'd0) begin
						e_q      <= e_q + 18'sd1;
						div_n_q  <= x_q;
						div_d_q  <= pw10(5'd1);
						rk_q     <= 5'd1;
						div_go_q <= 1'b1;
						ret_q    <= DIV_T;
						state_q  <= DWAIT;
					end else begin
						mag_q   <= x_q[63:0];
						state_q <= FIN;
					end
				end
				DIV_T: begin
					x_q     <= qr;
					state_q <= DIV_BIG;
				end
				FIN: begin
					st_q <= ST_OK;
					if (e_q < EXP_MIN) begin
						e_q <= EXP_MIN;
						if (m_lo > 18'sd19) begin
							mag_q   <= '0;
							state_q <= EMIT;
						end else begin
							div_n_q  <= {64'd0, mag_q};
							div_d_q  <= pw10(m_lo[4:0]);
							rk_q     <= m_lo[4:0];
							div_go_q <= 1'b1;
							ret_q    <= FIN_R;
							state_q  <= DWAIT;
						end
					end else if (e_q > EXP_MAX && mag_q == 64'd0) begin
						e_q     <= EXP_MAX;
						state_q <= EMIT;
					end else if (e_q > EXP_MAX) begin
						state_q <= FIN_HI;
					end else begin
						state_q <= EMIT;
					end
				end
				FIN_R: begin
					mag_q   <= qr[63:0];
					state_q <= EMIT;
				end
				FIN_HI: begin
					if (e_q > EXP_MAX) begin
						if (mag_q > COEF_TENTH) begin
							st_q    <= ST_RANGE;
							state_q <= EMIT;
						end else begin
							mag_q <= mul10_64(mag_q);
							e_q   <= e_q - 18'sd1;
						end
					end else begin
						state_q <= EMIT;
					end
				end
				DWAIT: begin
					if (div_done)
						state_q <= ret_q;
				end
				EMIT: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						if (st_q != ST_OK) begin
							res_q.res_coef <= '0;
							res_q.res_exp  <= '0;
						end else begin
							res_q.res_coef <= neg_q ? 64'd0 - mag_q : mag_q;
							res_q.res_exp  <= e_q[15:0];
						end
						res_q.status <= st_q;
						state_q      <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign op_stall  = (state_q != IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ===== design/dau_div.sv =====
// ----------------------------------------------------------------------------
// dau_div
// Restoring 128 by 64 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dau_div (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         go,
	input  wire logic [127:0] num,
	input  wire logic [63:0]  den,
	output logic              done,
	output logic [127:0]      quo,
	output logic [63:0]       rem
);
	logic [127:0] nq_q;
	logic [63:0]  r_q;
	logic [63:0]  d_q;
	logic [6:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [63:0]  rs;
	logic         ge;

	assign rs = {r_q[62:0], nq_q[127]};
	assign ge = r_q[63] || (rs >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			nq_q <= num;
			r_q  <= '0;
			d_q  <= den;
		end else if (busy_q) begin
			nq_q <= {nq_q[126:0], ge};
			r_q  <= ge ? rs - d_q : rs;
		end
	end

	assign done = done_q;
	assign quo  = nq_q;
	assign rem  = r_q;

endmodule

`default_nettype wire

// ===== design/dau_mul.sv =====
// ----------------------------------------------------------------------------
// dau_mul
// Shift-add 64 by 64 multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dau_mul (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [127:0]     prod
);
	logic [127:0] p_q;
	logic [63:0]  a_q;
	logic [5:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [64:0]  sum;

	assign sum = {1'b0, p_q[127:64]} + (p_q[0] ? {1'b0, a_q} : 65'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			p_q <= {64'd0, b};
			a_q <= a;
		end else if (busy_q) begin
			p_q <= {sum, p_q[63:1]};
		end
	end

	assign done = done_q;
	assign prod = p_q;

endmodule

`default_nettype wire
